FILE: rtl/rqs_pkg.sv
`timescale 1ns / 1ps

package rqs_pkg;

  localparam int FUNC_W        = 2;
  localparam int PORT_W        = 2;
  localparam int QP_W          = 24;
  localparam int QCNT_W        = 8;
  localparam int TIDX_W        = 9;
  localparam int QUEUE_W       = 16;
  localparam int SIZE_W        = 10;
  localparam int HASH_W        = 32;
  localparam int KEY_W         = 64;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SIZE   = 2'd2;

  localparam logic [KEY_W-1:0] KEY_RESET = 64'h6d5a_56da_255b_0ec2;

  localparam int PORTS_DEF       = 4;
  localparam int TABLE_DEPTH_DEF = 512;

  // The hash covers the id bits only; the low byte of the hashed word is zero.
  localparam int HASH_STAGES = 3;
  localparam int HASH_BITS   = QP_W / HASH_STAGES;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STAGES  = HASH_W / DIV_BITS;

  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] acc,
                                                  input logic [QP_W-1:0] qp,
                                                  input logic [KEY_W-1:0] key,
                                                  input int grp);
    logic [HASH_W-1:0] a;
    int i;
    a = acc;
    for (int j = 0; j < HASH_BITS; j++) begin
      i = grp * HASH_BITS + j;
      if (qp[QP_W-1-i]) begin
        a = a ^ key[KEY_W-1-i -: HASH_W];
      end
    end
    return a;
  endfunction

  function automatic logic [SIZE_W-1:0] div_step(input logic [SIZE_W-1:0] rem,
                                                 input logic [SIZE_W-1:0] divisor,
                                                 input logic [HASH_W-1:0] dividend,
                                                 input int grp);
    logic [SIZE_W-1:0] r;
    logic [SIZE_W:0] t;
    r = rem;
    for (int j = 0; j < DIV_BITS; j++) begin
      t = {r, dividend[HASH_W-1-(grp*DIV_BITS+j)]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[SIZE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/rss_queue_select_core.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// in        in_valid / in_stall   func, port, qp_id, queue_count, table_index,
//                                 table_value, table_size
// out       out_valid / out_stall queue, hash, from_table
// cfg       cfg_valid / cfg_ready cfg_data (hash key head)
//
// One transaction per cycle is accepted while in_stall is low. The pipeline has three
// hash stages, eight remainder stages of four bits each and one redirection table
// read stage.
// Reset clears the valid bits, the port table sizes and restores the key.
// A stalled output holds its result while empty stages upstream still fill.

module rss_queue_select_core #(
  parameter int PORTS       = rqs_pkg::PORTS_DEF,
  parameter int TABLE_DEPTH = rqs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rqs_pkg::FUNC_W-1:0]   func,
  input  logic [rqs_pkg::PORT_W-1:0]   port,
  input  logic [rqs_pkg::QP_W-1:0]     qp_id,
  input  logic [rqs_pkg::QCNT_W-1:0]   queue_count,
  input  logic [rqs_pkg::TIDX_W-1:0]   table_index,
  input  logic [rqs_pkg::QUEUE_W-1:0]  table_value,
  input  logic [rqs_pkg::SIZE_W-1:0]   table_size,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rqs_pkg::QUEUE_W-1:0]  queue,
  output logic [rqs_pkg::HASH_W-1:0]   hash,
  output logic                         from_table,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rqs_pkg::KEY_W-1:0]    cfg_data
);
  import rqs_pkg::*;

  localparam int ENTRIES = PORTS * TABLE_DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW      = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int NSTG    = HASH_STAGES + DIV_STAGES + 1;
  localparam int MEM_STG = NSTG - 1;

  typedef struct packed {
    logic                is_write;
    logic [ADDR_W-1:0]   addr;
    logic [QUEUE_W-1:0]  wdata;
    logic [QP_W-1:0]     qp;
    logic [HASH_W-1:0]   acc;
    logic                use_table;
    logic                qzero;
    logic [SIZE_W-1:0]   divisor;
    logic [SIZE_W-1:0]   rem;
  } pipe_t;

  logic [KEY_W-1:0]   hash_key_head;
  logic [SIZE_W-1:0]  port_table_size [PORTS];
  logic [QUEUE_W-1:0] queue_table [ENTRIES];
  logic [QUEUE_W-1:0] rdata;

  pipe_t            stg [NSTG];
  pipe_t            nxt [NSTG];
  logic [NSTG-1:0]  vld;
  logic [NSTG:0]    load;

  logic             port_ok;
  logic             write_ok;
  logic             in_take;
  logic [SIZE_W-1:0] cur_size;
  logic [ADDR_W-1:0] rd_addr;

  assign cfg_ready = 1'b1;

  assign port_ok  = int'(port) < PORTS;
  assign write_ok = (func == FUNC_WRITE) && port_ok && (int'(table_index) < TABLE_DEPTH);
  assign cur_size = port_ok ? port_table_size[PW'(port)] : '0;
  assign in_stall = !load[0];
  assign in_take  = in_valid && load[0] && ((func == FUNC_LOOKUP) || write_ok);

  always_comb begin
    load[NSTG] = !out_valid || !out_stall;
    for (int k = NSTG - 1; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  always_comb begin
    nxt[0].is_write  = (func == FUNC_WRITE);
    nxt[0].addr      = (func == FUNC_WRITE)
                     ? ADDR_W'(int'(port) * TABLE_DEPTH + int'(table_index))
                     : ADDR_W'(int'(port) * TABLE_DEPTH);
    nxt[0].wdata     = table_value;
    nxt[0].qp        = qp_id;
    nxt[0].acc       = hash_step('0, qp_id, hash_key_head, 0);
    nxt[0].use_table = (cur_size != '0);
    nxt[0].qzero     = (cur_size == '0) && (queue_count == '0);
    nxt[0].divisor   = (cur_size != '0) ? cur_size : SIZE_W'(queue_count);
    nxt[0].rem       = '0;
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_stage
    always_comb begin
      nxt[k] = stg[k-1];
      if (k < HASH_STAGES) begin
        nxt[k].acc = hash_step(stg[k-1].acc, stg[k-1].qp, hash_key_head, k);
      end else if (k < HASH_STAGES + DIV_STAGES) begin
        nxt[k].rem = div_step(stg[k-1].rem, stg[k-1].divisor, stg[k-1].acc,
                              k - HASH_STAGES);
      end
    end
  end

  assign rd_addr = stg[MEM_STG-1].addr + ADDR_W'(stg[MEM_STG-1].rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_key_head <= KEY_RESET;
      for (int p = 0; p < PORTS; p++) begin
        port_table_size[p] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        hash_key_head <= cfg_data;
      end
      if (in_valid && load[0] && (func == FUNC_SIZE) && port_ok) begin
        port_table_size[PW'(port)] <= (int'(table_size) > TABLE_DEPTH)
                                    ? SIZE_W'(TABLE_DEPTH) : table_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (load[k]) begin
          vld[k] <= (k == 0) ? in_take : vld[(k == 0) ? 0 : k - 1];
        end
      end
      if (load[NSTG]) begin
        out_valid <= vld[MEM_STG] && !stg[MEM_STG].is_write;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (load[k]) begin
        stg[k] <= nxt[k];
      end
    end
    if (load[NSTG]) begin
      hash       <= stg[MEM_STG].acc;
      from_table <= stg[MEM_STG].use_table;
      if (stg[MEM_STG].use_table) begin
        queue <= rdata;
      end else if (stg[MEM_STG].qzero) begin
        queue <= '0;
      end else begin
        queue <= QUEUE_W'(stg[MEM_STG].rem);
      end
    end
  end

  // Table writes are applied here, in order with the lookups that read the table.
  always_ff @(posedge clk) begin
    if (load[MEM_STG]) begin
      if (vld[MEM_STG-1] && stg[MEM_STG-1].is_write) begin
        queue_table[stg[MEM_STG-1].addr] <= stg[MEM_STG-1].wdata;
      end
      rdata <= queue_table[rd_addr];
    end
  end

endmodule

FILE: rtl/rqs_checker.sv
`timescale 1ns / 1ps

module rqs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [rqs_pkg::QUEUE_W-1:0]  queue,
  input logic [rqs_pkg::HASH_W-1:0]   hash,
  input logic                         from_table
);
  import rqs_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output side can drain");

  a_fallback_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !from_table) |-> (queue[QUEUE_W-1:QCNT_W] == '0))
    else $error("fallback queue beyond the queue count range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(queue) && $stable(hash) && $stable(from_table)))
    else $error("stalled result changed");

endmodule

bind rss_queue_select_core rqs_checker u_rqs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .queue      (queue),
  .hash       (hash),
  .from_table (from_table)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rqs_pkg::*;

  localparam int PORT_COUNT = PORTS_DEF;
  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [PORT_W-1:0]  port;
    logic [QP_W-1:0]    qp_id;
    logic [QCNT_W-1:0]  queue_count;
    logic [TIDX_W-1:0]  table_index;
    logic [QUEUE_W-1:0] table_value;
    logic [SIZE_W-1:0]  table_size;
  } rss_txn_t;

  typedef struct {
    logic [QUEUE_W-1:0] queue;
    logic [HASH_W-1:0]  hash;
    logic               from_table;
  } rss_result_t;

  class rss_selection_model;
    logic [KEY_W-1:0]   key;
    logic [QUEUE_W-1:0] redir[PORT_COUNT][DEPTH];
    bit                 written[PORT_COUNT][DEPTH];
    logic [SIZE_W-1:0]  size_of[PORT_COUNT];
    rss_result_t        expected[$];
    int                 errors;

    function new();
      key = KEY_RESET;
      errors = 0;
      foreach (size_of[p]) size_of[p] = '0;
    endfunction

    function logic [HASH_W-1:0] toeplitz_hash(logic [HASH_W-1:0] word);
      logic [HASH_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < HASH_W; i++) begin
        if (word[HASH_W-1-i]) begin
          acc = acc ^ key[KEY_W-1-i -: HASH_W];
        end
      end
      return acc;
    endfunction

    // Returns the table entry a lookup would read if it was never written, else -1.
    function int unwritten_slot(rss_txn_t t);
      logic [HASH_W-1:0] h;
      int slot;
      if (t.func != FUNC_LOOKUP || size_of[t.port] == 0) begin
        return -1;
      end
      h = toeplitz_hash({t.qp_id, 8'h00});
      slot = int'(h % size_of[t.port]);
      return written[t.port][slot] ? -1 : slot;
    endfunction

    function void note_input(rss_txn_t t);
      rss_result_t r;
      logic [HASH_W-1:0] h;
      case (t.func)
        FUNC_WRITE: begin
          redir[t.port][t.table_index] = t.table_value;
          written[t.port][t.table_index] = 1'b1;
        end
        FUNC_SIZE: begin
          size_of[t.port] = (t.table_size > DEPTH) ? SIZE_W'(DEPTH) : t.table_size;
        end
        FUNC_LOOKUP: begin
          h = toeplitz_hash({t.qp_id, 8'h00});
          r.hash = h;
          if (size_of[t.port] != 0) begin
            r.queue = redir[t.port][h % size_of[t.port]];
            r.from_table = 1'b1;
          end else begin
            r.queue = (t.queue_count == 0) ? '0 : QUEUE_W'(h % t.queue_count);
            r.from_table = 1'b0;
          end
          expected.push_back(r);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [QUEUE_W-1:0] q, logic [HASH_W-1:0] h, logic ft);
      rss_result_t r;
      if (expected.size() == 0) begin
        $error("unexpected result: queue %0h hash %0h from_table %0b", q, h, ft);
        errors++;
        return;
      end
      r = expected.pop_front();
      if (q !== r.queue) begin
        $error("queue: expected %0h, actual %0h", r.queue, q);
        errors++;
      end
      if (h !== r.hash) begin
        $error("hash: expected %0h, actual %0h", r.hash, h);
        errors++;
      end
      if (ft !== r.from_table) begin
        $error("from_table: expected %0b, actual %0b", r.from_table, ft);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   func = '0;
  logic [PORT_W-1:0]   port = '0;
  logic [QP_W-1:0]     qp_id = '0;
  logic [QCNT_W-1:0]   queue_count = '0;
  logic [TIDX_W-1:0]   table_index = '0;
  logic [QUEUE_W-1:0]  table_value = '0;
  logic [SIZE_W-1:0]   table_size = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [QUEUE_W-1:0]  queue;
  logic [HASH_W-1:0]   hash;
  logic                from_table;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [KEY_W-1:0]    cfg_data = '0;

  rss_selection_model selector;
  int gap_pct = 31;
  int stall_pct = 49;
  int results_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  rss_queue_select_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .port(port), .qp_id(qp_id), .queue_count(queue_count),
    .table_index(table_index), .table_value(table_value), .table_size(table_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .queue(queue), .hash(hash), .from_table(from_table),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver holds off for a long stretch twice so that the pipeline backs up.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      selector.check_result(queue, hash, from_table);
      results_seen++;
      if (results_seen == 60 || results_seen == 300) begin
        hold_left = 200;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic rss_txn_t make_txn(logic [FUNC_W-1:0] f, logic [PORT_W-1:0] p,
                                        logic [QP_W-1:0] qp, logic [QCNT_W-1:0] qc,
                                        logic [TIDX_W-1:0] idx, logic [QUEUE_W-1:0] val,
                                        logic [SIZE_W-1:0] sz);
    rss_txn_t t;
    t.func = f;
    t.port = p;
    t.qp_id = qp;
    t.queue_count = qc;
    t.table_index = idx;
    t.table_value = val;
    t.table_size = sz;
    return t;
  endfunction

  function automatic rss_txn_t random_txn();
    rss_txn_t t;
    int pick;
    t = make_txn(FUNC_LOOKUP, PORT_W'($urandom), QP_W'($urandom), QCNT_W'($urandom),
                 TIDX_W'($urandom), QUEUE_W'($urandom), SIZE_W'($urandom));
    pick = $urandom_range(99);
    if (pick < 55) t.func = FUNC_LOOKUP;
    else if (pick < 80) t.func = FUNC_WRITE;
    else if (pick < 95) t.func = FUNC_SIZE;
    else t.func = FUNC_UNUSED;
    if ($urandom_range(1) == 1) begin
      t.table_index = TIDX_W'($urandom_range(31));
    end
    pick = $urandom_range(99);
    if (pick < 10) t.table_size = '0;
    else if (pick < 70) t.table_size = SIZE_W'($urandom_range(16, 1));
    else if (pick < 85) t.table_size = SIZE_W'($urandom_range(512, 17));
    else t.table_size = SIZE_W'($urandom_range(1023, 513));
    return t;
  endfunction

  task automatic push_txn(input rss_txn_t t);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= t.func;
    port <= t.port;
    qp_id <= t.qp_id;
    queue_count <= t.queue_count;
    table_index <= t.table_index;
    table_value <= t.table_value;
    table_size <= t.table_size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    selector.note_input(t);
  endtask

  // A lookup that would land on a never-written entry gets that entry filled first.
  task automatic issue(input rss_txn_t t);
    int slot;
    slot = selector.unwritten_slot(t);
    if (slot >= 0) begin
      push_txn(make_txn(FUNC_WRITE, t.port, '0, '0, TIDX_W'(slot),
                        QUEUE_W'($urandom), '0));
    end
    push_txn(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (selector.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(input logic [KEY_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    selector.key = value;
  endtask

  task automatic random_run(input int count);
    for (int n = 0; n < count; n++) begin
      issue(random_txn());
    end
    drain();
  endtask

  initial begin
    selector = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(make_txn(FUNC_LOOKUP, 2'd0, '0, '0, '0, '0, '0));
    issue(make_txn(FUNC_LOOKUP, 2'd0, '1, '1, '1, '1, '1));
    issue(make_txn(FUNC_LOOKUP, 2'd3, 24'h000001, 8'd1, '0, '0, '0));
    issue(make_txn(FUNC_LOOKUP, 2'd2, 24'h800000, 8'd7, '0, '0, '0));
    issue(make_txn(FUNC_UNUSED, 2'd1, '1, '1, '1, '1, '1));
    issue(make_txn(FUNC_WRITE, 2'd1, '0, '0, 9'd0, 16'hffff, '0));
    issue(make_txn(FUNC_WRITE, 2'd1, '0, '0, 9'd511, 16'h0000, '0));
    issue(make_txn(FUNC_WRITE, 2'd1, '0, '0, 9'd1, 16'h1234, '0));
    issue(make_txn(FUNC_SIZE, 2'd1, '0, '0, '0, '0, 10'd1));
    issue(make_txn(FUNC_LOOKUP, 2'd1, 24'h123456, 8'd9, '0, '0, '0));
    issue(make_txn(FUNC_SIZE, 2'd1, '0, '0, '0, '0, 10'd2));
    issue(make_txn(FUNC_LOOKUP, 2'd1, 24'hfedcba, 8'd3, '0, '0, '0));
    issue(make_txn(FUNC_LOOKUP, 2'd1, 24'h00ff00, 8'd0, '0, '0, '0));
    issue(make_txn(FUNC_SIZE, 2'd2, '0, '0, '0, '0, 10'd1023));
    issue(make_txn(FUNC_LOOKUP, 2'd2, 24'habcdef, 8'd5, '0, '0, '0));
    issue(make_txn(FUNC_SIZE, 2'd3, '0, '0, '0, '0, 10'd512));
    issue(make_txn(FUNC_LOOKUP, 2'd3, 24'h5a5a5a, 8'd200, '0, '0, '0));
    issue(make_txn(FUNC_SIZE, 2'd2, '0, '0, '0, '0, 10'd0));
    issue(make_txn(FUNC_LOOKUP, 2'd2, 24'habcdef, 8'd255, '0, '0, '0));
    issue(make_txn(FUNC_WRITE, 2'd0, '0, '0, TIDX_W'($urandom), QUEUE_W'($urandom), '0));
    drain();

    load_key('1);
    random_run(250);
    load_key('0);
    random_run(20);

    gap_pct = 49;
    stall_pct = 31;
    load_key({$urandom, $urandom});
    random_run(250);

    gap_pct = 0;
    stall_pct = 0;
    load_key({$urandom, $urandom});
    random_run(250);

    if (selector.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rqs_pkg.sv
rtl/rss_queue_select_core.sv
rtl/rqs_checker.sv
tb/testbench.sv
